@@ hdl/rvt_pkg.sv @@
// rvt_pkg: shared types, constants and helpers for the range velocity tracker
// used by rvt_divider and range_velocity_tracker; depends on nothing else
`timescale 1ns / 1ps

package rvt_pkg;

  localparam int RING_DEPTH = 16;
  localparam int RING_IDX_W = $clog2(RING_DEPTH);

  localparam int DIST_W = 16;
  localparam int TIME_W = 32;
  localparam int VEL_W  = 32;
  localparam int CNT_W  = 2;

  // ring entry: {time_us, distance_cm}
  localparam int RING_W = DIST_W + TIME_W;

  // 17-bit signed distance step times 10^7 fits 41 bits signed
  localparam int DIFF_W = DIST_W + 1;
  localparam int DVD_W  = 41;
  localparam int DVS_W  = 32;

  localparam logic [23:0] VEL_SCALE    = 24'd10000000;
  localparam logic [13:0] IMPACT_SCALE = 14'd10000;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 2;

  typedef enum logic {
    OP_READING = 1'b0,
    OP_QUERY   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_ANSWER   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_MIN_RANGE    = 2'd0,
    REG_MAX_RANGE    = 2'd1,
    REG_MIN_INTERVAL = 2'd2,
    REG_STALE_TIME   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quotient;
  } div_rsp_t;

  function automatic logic [RING_IDX_W-1:0] next_slot(input logic [RING_IDX_W-1:0] x);
    logic [RING_IDX_W-1:0] r;
    if (x == RING_IDX_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = x + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [RING_IDX_W-1:0] prev_slot(input logic [RING_IDX_W-1:0] x);
    logic [RING_IDX_W-1:0] r;
    if (x == '0) begin
      r = RING_IDX_W'(RING_DEPTH - 1);
    end else begin
      r = x - 1'b1;
    end
    return r;
  endfunction

endpackage

@@ hdl/rvt_divider.sv @@
// rvt_divider: unsigned restoring divider, one quotient bit per cycle
// depends on rvt_pkg for widths and the request/response structs
`timescale 1ns / 1ps

module rvt_divider import rvt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;

  logic [DVD_W-1:0]  acc_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  den_q;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, acc_q[DVD_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DVD_W);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      acc_q <= {acc_q[DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = acc_q;

endmodule

@@ hdl/range_velocity_tracker.sv @@
// range_velocity_tracker: ring of timestamped range readings with smoothed
// distance, velocity and time to impact; uses rvt_pkg and rvt_divider
//
//   channel   dir   handshake                 contents
//   s_axis    in    tvalid/tready             tdata: distance, time; tuser: op
//   m_axis    out   tvalid/tready             tdata: range, velocity, impact; tuser: status
//   apb       in    psel/penable, pready=1    four configuration registers
//
// queries and rejected readings go from accept through S_READ to S_OUT, where
// the result register loads once free; accepted readings pass S_VSTART, S_VDIV,
// S_SMOOTH and S_IMUL, then when closing S_IDIV: two passes of the bit-serial
// divider, raw velocity, then time to impact; otherwise the second pass is skipped
// one item is in flight at a time; the result register lets the next item in
// while the previous result waits on m_axis_tready_i
// reset is asynchronous, active low; the ring memory is not cleared
`timescale 1ns / 1ps

module range_velocity_tracker import rvt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [15:0] distance_cm, [47:16] time_us
  input  logic [IN_DATA_W-1:0]   s_axis_tdata_i,
  // [0] op
  input  logic [0:0]             s_axis_tuser_i,

  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [15:0] range_out_cm, [47:16] velocity_mm_s, [79:48] impact_time_ms
  output logic [OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [OUT_USER_W-1:0]  m_axis_tuser_o,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_VSTART = 8'b0000_0100,
    S_VDIV   = 8'b0000_1000,
    S_SMOOTH = 8'b0001_0000,
    S_IMUL   = 8'b0010_0000,
    S_IDIV   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  // configuration
  logic [DIST_W-1:0] min_range_q;
  logic [DIST_W-1:0] max_range_q;
  logic [TIME_W-1:0] min_interval_q;
  logic [TIME_W-1:0] stale_time_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  // tracker state
  state_e                state_q, state_d;
  logic [RING_IDX_W-1:0] write_idx_q;
  logic [RING_IDX_W-1:0] lag_idx_q;
  logic [CNT_W-1:0]      count_q;
  logic [DIST_W-1:0]     smooth_rng_q;
  logic [VEL_W-1:0]      smooth_vel_q;
  logic [VEL_W-1:0]      impact_q;

  // item in flight
  op_e                   op_q;
  logic [DIST_W-1:0]     dist_q;
  logic [TIME_W-1:0]     time_q;
  logic                  win_q;
  logic                  stale_q;
  logic                  vel_zero_q;
  logic signed [DVD_W-1:0] dx_q;
  logic [TIME_W-1:0]     dt_q;
  logic [VEL_W-1:0]      vel_raw_q;

  // ring memory
  logic [RING_W-1:0]     ring_mem [RING_DEPTH];
  logic [RING_W-1:0]     ring_rd_q;
  logic                  ring_re;
  logic                  ring_we;
  logic [RING_IDX_W-1:0] ring_rd_addr;
  logic [DIST_W-1:0]     rd_dist;
  logic [TIME_W-1:0]     rd_time;

  // output register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [OUT_USER_W-1:0] m_user_q;
  logic                  out_load;

  // datapath
  logic                  in_acc;
  logic [DIST_W-1:0]     in_dist;
  logic [TIME_W-1:0]     in_time;
  logic signed [DIFF_W-1:0] dist_diff;
  logic signed [DVD_W-1:0]  dx_prod;
  logic [TIME_W-1:0]     dt_now;
  logic [DVD_W-1:0]      dx_mag;
  logic [DVD_W-1:0]      quo;
  logic [VEL_W-1:0]      vel_sat;
  logic [DIST_W+2-1:0]   rng_sum;
  logic [DIST_W-1:0]     rng_new;
  logic signed [VEL_W+1:0] vel_sum;
  logic signed [VEL_W+1:0] vel_adj;
  logic [VEL_W-1:0]      vel_new;
  logic [RING_IDX_W-1:0] wi_next;
  logic                  lag_adv;
  logic [29:0]           impact_num;
  logic [VEL_W-1:0]      vel_neg;
  status_e               out_status;
  logic [DIST_W-1:0]     out_rng;
  logic [VEL_W-1:0]      out_vel;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_RANGE:    prdata = CFG_DATA_W'(min_range_q);
      REG_MAX_RANGE:    prdata = CFG_DATA_W'(max_range_q);
      REG_MIN_INTERVAL: prdata = min_interval_q;
      REG_STALE_TIME:   prdata = stale_time_q;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q    <= 16'd20;
      max_range_q    <= 16'd2500;
      min_interval_q <= 32'd50000;
      stale_time_q   <= 32'd100000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_RANGE:    min_range_q    <= pwdata[DIST_W-1:0];
        REG_MAX_RANGE:    max_range_q    <= pwdata[DIST_W-1:0];
        REG_MIN_INTERVAL: min_interval_q <= pwdata;
        REG_STALE_TIME:   stale_time_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_dist = s_axis_tdata_i[15:0];
  assign in_time = s_axis_tdata_i[47:16];

  // ---------------------------------------------------------------- ring
  // a query looks at the newest entry, a reading at the lag entry
  assign ring_re      = in_acc;
  assign ring_rd_addr = (op_e'(s_axis_tuser_i[0]) == OP_QUERY) ? prev_slot(write_idx_q)
                                                                : lag_idx_q;
  assign ring_we      = (state_q == S_SMOOTH);
  assign rd_dist      = ring_rd_q[DIST_W-1:0];
  assign rd_time      = ring_rd_q[RING_W-1:DIST_W];

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[write_idx_q] <= {time_q, dist_q};
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_rd_addr];
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    dt_now    = time_q - rd_time;
    dist_diff = $signed({1'b0, dist_q}) - $signed({1'b0, rd_dist});
    dx_prod   = $signed({{(DVD_W-DIFF_W){dist_diff[DIFF_W-1]}}, dist_diff})
              * $signed({{(DVD_W-24){1'b0}}, VEL_SCALE});
    dx_mag    = dx_q[DVD_W-1] ? DVD_W'(-dx_q) : DVD_W'(dx_q);

    // truncate toward zero on magnitudes, then saturate to 32 bits signed
    quo = div_rsp.quotient;
    if (!dx_q[DVD_W-1]) begin
      vel_sat = (quo > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[VEL_W-1:0];
    end else begin
      vel_sat = (quo > DVD_W'(32'h8000_0000)) ? 32'h8000_0000 : VEL_W'(-quo[VEL_W-1:0]);
    end

    rng_sum = {2'b00, smooth_rng_q} + {1'b0, smooth_rng_q, 1'b0} + {2'b00, dist_q};
    rng_new = (count_q == '0) ? dist_q : rng_sum[DIST_W+1:2];

    vel_sum = $signed({{2{smooth_vel_q[VEL_W-1]}}, smooth_vel_q})
            + $signed({smooth_vel_q[VEL_W-1], smooth_vel_q, 1'b0})
            + $signed({{2{vel_raw_q[VEL_W-1]}}, vel_raw_q});
    vel_adj = vel_sum + (vel_sum[VEL_W+1] ? 34'sd3 : 34'sd0);
    if (count_q == CNT_W'(1)) begin
      vel_new = vel_raw_q;
    end else begin
      vel_new = vel_adj[VEL_W+1:2];
    end

    wi_next = next_slot(write_idx_q);
    lag_adv = (count_q != '0) && ((wi_next == lag_idx_q) || (dt_q > min_interval_q));

    impact_num = smooth_rng_q * IMPACT_SCALE;
    vel_neg    = ~smooth_vel_q + 1'b1;
  end

  always_comb begin
    div_req.start    = (state_q == S_VSTART) || ((state_q == S_IMUL) && smooth_vel_q[VEL_W-1]);
    div_req.dividend = (state_q == S_VSTART) ? dx_mag : DVD_W'(impact_num);
    div_req.divisor  = (state_q == S_VSTART) ? dt_q : vel_neg;
  end

  rvt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_READ;
      S_READ: begin
        if (op_q == OP_READING && win_q) state_d = S_VSTART;
        else                             state_d = S_OUT;
      end
      S_VSTART: state_d = S_VDIV;
      S_VDIV:   if (div_rsp.done) state_d = S_SMOOTH;
      S_SMOOTH: state_d = S_IMUL;
      S_IMUL:   state_d = smooth_vel_q[VEL_W-1] ? S_IDIV : S_OUT;
      S_IDIV:   if (div_rsp.done) state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      write_idx_q  <= '0;
      lag_idx_q    <= '0;
      count_q      <= '0;
      smooth_rng_q <= '0;
      smooth_vel_q <= '0;
      impact_q     <= '1;
    end else begin
      state_q <= state_d;
      if (state_q == S_SMOOTH) begin
        write_idx_q  <= wi_next;
        smooth_rng_q <= rng_new;
        if (count_q != '0) begin
          smooth_vel_q <= vel_new;
        end
        if (lag_adv) begin
          lag_idx_q <= next_slot(lag_idx_q);
        end
        if (count_q != CNT_W'(2)) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (state_q == S_IMUL && !smooth_vel_q[VEL_W-1]) begin
        impact_q <= '1;
      end else if (state_q == S_IDIV && div_rsp.done) begin
        impact_q <= div_rsp.quotient[VEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(s_axis_tuser_i[0]);
      dist_q <= in_dist;
      time_q <= in_time;
      win_q  <= (in_dist >= min_range_q) && (in_dist <= max_range_q);
    end
    if (state_q == S_READ) begin
      stale_q    <= (count_q == '0) || (dt_now > stale_time_q);
      dx_q       <= dx_prod;
      dt_q       <= dt_now;
      vel_zero_q <= (lag_idx_q == write_idx_q) || (dt_now == '0);
    end
    if (state_q == S_VDIV && div_rsp.done) begin
      vel_raw_q <= vel_zero_q ? '0 : vel_sat;
    end
  end

  // ---------------------------------------------------------------- output
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    if (op_q == OP_QUERY) begin
      out_status = STATUS_ANSWER;
    end else if (win_q) begin
      out_status = STATUS_ACCEPTED;
    end else begin
      out_status = STATUS_REJECTED;
    end
    out_rng = (op_q == OP_QUERY && stale_q) ? max_range_q : smooth_rng_q;
    out_vel = (op_q == OP_QUERY && stale_q) ? '0 : smooth_vel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {impact_q, out_vel, out_rng};
      m_user_q <= out_status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // ---------------------------------------------------------------- checks
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("item accepted while another is in flight");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != CNT_W'(3))
    else $error("reading count past saturation");

  a_lag_behind_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (lag_idx_q != write_idx_q))
    else $error("lag entry caught by write entry");

  a_ring_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (op_q == OP_READING && win_q))
    else $error("ring written for a query or rejected reading");

  a_impact_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !smooth_vel_q[VEL_W-1]) |-> (impact_q == '1))
    else $error("impact time not all ones for a receding target");

endmodule

@@ test/tb_range_velocity_tracker.sv @@
// tb_range_velocity_tracker: self-checking bench for range_velocity_tracker,
// directed then random readings and queries against an in-bench tracker copy
// depends on rvt_pkg and the range_velocity_tracker rtl
`timescale 1ns / 1ps

module tb_range_velocity_tracker;
  import rvt_pkg::*;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  DRAIN_CYCLES   = 200;
  localparam longint VEL_MAX     = 64'sd2147483647;
  localparam longint VEL_MIN     = -64'sd2147483648;

  typedef struct {
    op_e         op;
    logic [15:0] dist_cm;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] range_cm;
    logic [31:0] vel_mm_s;
    logic [31:0] impact_ms;
  } report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_valid = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  range_velocity_tracker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // tracker copy: configuration, ring and smoothed values
  logic [15:0] cfg_min      = 16'd20;
  logic [15:0] cfg_max      = 16'd2500;
  logic [31:0] cfg_interval = 32'd50000;
  logic [31:0] cfg_stale    = 32'd100000;

  logic [DIST_W-1:0]     range_mem [RING_DEPTH];
  logic [TIME_W-1:0]     stamp_mem [RING_DEPTH];
  logic [RING_IDX_W-1:0] wr_slot  = '0;
  logic [RING_IDX_W-1:0] lag_slot = '0;
  int unsigned           seen_count = 0;
  logic [15:0]           avg_range  = '0;
  logic signed [31:0]    avg_vel    = '0;

  sample_t pending_samples[$];
  report_t expected_reports[$];
  sample_t on_bus;
  int      mismatch_count = 0;

  // generator state
  logic [31:0] now_us         = '0;
  logic [31:0] last_accept_us = '0;
  int          track_cm       = 1500;
  bit          closing        = 1'b1;

  function automatic logic [31:0] impact_of(logic [15:0] r, logic signed [31:0] v);
    longint unsigned num;
    longint unsigned den;
    longint          sv;
    if (v >= 0) return '1;
    sv  = v;
    num = 64'(r) * 64'd10000;
    den = -sv;
    return 32'(num / den);
  endfunction

  // one item through the tracker copy, returns the word it should produce
  function automatic report_t track_item(op_e op, logic [15:0] dist_cm, logic [31:0] t);
    report_t               rep;
    logic [RING_IDX_W-1:0] lag_now;
    logic [RING_IDX_W-1:0] last_slot;
    logic [31:0]           lag_stamp;
    logic [31:0]           dt;
    longint                dx;
    longint                raw;
    longint                mix;
    logic signed [31:0]    vel;
    logic                  stale;
    if (op == OP_READING) begin
      if (dist_cm >= cfg_min && dist_cm <= cfg_max) begin
        lag_now   = lag_slot;
        lag_stamp = stamp_mem[lag_now];
        vel       = '0;
        if (lag_now != wr_slot) begin
          dt = t - stamp_mem[lag_now];
          if (dt != 0) begin
            dx  = (longint'(dist_cm) - longint'(range_mem[lag_now])) * 64'sd10000000;
            raw = dx / longint'({32'd0, dt});
            if (raw > VEL_MAX) raw = VEL_MAX;
            if (raw < VEL_MIN) raw = VEL_MIN;
            vel = 32'(raw);
          end
        end
        range_mem[wr_slot] = dist_cm;
        stamp_mem[wr_slot] = t;
        wr_slot = wr_slot + 1'b1;
        if (seen_count == 0) begin
          avg_range = dist_cm;
        end else begin
          avg_range = 16'((3 * int'(avg_range) + int'(dist_cm)) / 4);
          if (seen_count == 1) begin
            avg_vel = vel;
          end else begin
            mix     = 3 * longint'(avg_vel) + longint'(vel);
            avg_vel = 32'(mix / 4);
          end
          dt = t - lag_stamp;
          if (wr_slot == lag_now || dt > cfg_interval) lag_slot = lag_now + 1'b1;
        end
        if (seen_count < 2) seen_count++;
        rep.status = STATUS_ACCEPTED;
      end else begin
        rep.status = STATUS_REJECTED;
      end
      rep.range_cm = avg_range;
      rep.vel_mm_s = avg_vel;
    end else begin
      stale = 1'b1;
      if (seen_count != 0) begin
        last_slot = wr_slot - 1'b1;
        dt        = t - stamp_mem[last_slot];
        stale     = dt > cfg_stale;
      end
      rep.status   = STATUS_ANSWER;
      rep.range_cm = stale ? cfg_max : avg_range;
      rep.vel_mm_s = stale ? 32'd0 : avg_vel;
    end
    rep.impact_ms = impact_of(avg_range, avg_vel);
    return rep;
  endfunction

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    logic    next_valid;
    logic    taken;
    sample_t item;
    int      roll;
    next_valid = s_valid;
    taken      = s_valid && s_axis_tready_o;
    if (rst_ni) begin
      if (taken) expected_reports.push_back(track_item(on_bus.op, on_bus.dist_cm, on_bus.stamp));
      if (!s_valid || taken) begin
        if (gap_left != 0) begin
          gap_left--;
          next_valid = 1'b0;
        end else if (pending_samples.size() != 0) begin
          item       = pending_samples.pop_front();
          on_bus     = item;
          s_tdata    <= {item.stamp, item.dist_cm};
          s_tuser    <= item.op;
          next_valid = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            roll       = $urandom_range(0, 3);
            if (roll == 1) gap_left = $urandom_range(1, 4);
            else if (roll == 2) gap_left = $urandom_range(5, 120);
            else gap_left = 0;
          end
        end else begin
          next_valid = 1'b0;
        end
      end
    end
    s_valid <= next_valid;
  end

  // receiver: ready and stall runs of random length, with long ready stretches
  int hold_left = 0;

  always @(posedge clk_i) begin
    report_t want;
    int      roll;
    logic    next_ready;
    next_ready = m_ready;
    if (m_axis_tvalid_o === 1'b1 && m_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none, got tuser %0h tdata %0h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tuser_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o[15:0] !== want.range_cm) begin
          $display("%0t: range_out_cm expected %0d, got %0d",
                   $time, want.range_cm, m_axis_tdata_o[15:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[47:16] !== want.vel_mm_s) begin
          $display("%0t: velocity_mm_s expected %0d, got %0d",
                   $time, $signed(want.vel_mm_s), $signed(m_axis_tdata_o[47:16]));
          mismatch_count++;
        end
        if (m_axis_tdata_o[79:48] !== want.impact_ms) begin
          $display("%0t: impact_time_ms expected %0d, got %0d",
                   $time, want.impact_ms, m_axis_tdata_o[79:48]);
          mismatch_count++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
    end else begin
      roll = $urandom_range(0, 7);
      if (roll < 3) begin
        next_ready = 1'b1;
        hold_left  = $urandom_range(1, 60);
      end else if (roll == 3) begin
        next_ready = 1'b1;
        hold_left  = $urandom_range(200, 600);
      end else if (roll < 6) begin
        next_ready = 1'b0;
        hold_left  = $urandom_range(1, 8);
      end else if (roll == 6) begin
        next_ready = 1'b0;
        hold_left  = $urandom_range(20, 150);
      end else begin
        next_ready = 1'b0;
        hold_left  = 0;
      end
    end
    m_ready <= next_ready;
  end

  // watchdog on cycles with no word moving on either side
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o === 1'b1 && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** range_velocity_tracker: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_RANGE:    cfg_min      = val[15:0];
      REG_MAX_RANGE:    cfg_max      = val[15:0];
      REG_MIN_INTERVAL: cfg_interval = val;
      REG_STALE_TIME:   cfg_stale    = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] interval, input logic [31:0] stale);
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
    write_reg(REG_MIN_INTERVAL, interval);
    write_reg(REG_STALE_TIME, stale);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_valid || expected_reports.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic add_sample(input op_e op, input logic [15:0] dist_cm, input logic [31:0] stamp);
    pending_samples.push_back('{op, dist_cm, stamp});
  endtask

  // mostly a target moving inside the window, plus queries, misses and noise
  task automatic add_random_samples(input int count);
    int          lo;
    int          hi;
    int          span;
    int          step;
    int          pick;
    int          roll;
    op_e         op;
    logic [31:0] dt;
    logic [31:0] stamp;
    logic [15:0] dist_cm;
    for (int k = 0; k < count; k++) begin
      lo   = int'(cfg_min);
      hi   = int'(cfg_max);
      pick = $urandom_range(0, 99);
      roll = $urandom_range(0, 19);
      if (roll < 12) dt = $urandom_range(1000, 20000);
      else if (roll < 14) dt = $urandom_range(0, 3);
      else if (roll < 17) dt = $urandom_range(20000, 200000);
      else if (roll < 18) dt = cfg_interval + $urandom_range(0, 1);
      else dt = $urandom();
      op      = OP_READING;
      dist_cm = 16'($urandom_range(0, 65535));
      if (pick < 60) begin
        if (lo <= hi) begin
          span = (hi - lo) / 16 + 1;
          step = int'($urandom_range(0, 2 * span)) - span - (closing ? span / 2 : 0);
          track_cm = track_cm + step;
          if (track_cm < lo) track_cm = lo;
          if (track_cm > hi) track_cm = hi;
          if ($urandom_range(0, 19) == 0) track_cm = $urandom_range(0, 1) ? lo : hi;
          dist_cm = 16'(track_cm);
        end else begin
          dist_cm = 16'($urandom_range(hi, lo));
        end
        if ($urandom_range(0, 15) == 0) closing = !closing;
        now_us = now_us + dt;
        stamp  = now_us;
      end else if (pick < 80) begin
        op   = OP_QUERY;
        roll = $urandom_range(0, 4);
        if (roll == 0) stamp = now_us;
        else if (roll == 1) stamp = last_accept_us + cfg_stale;
        else if (roll == 2) stamp = last_accept_us + cfg_stale + 1;
        else if (roll == 3) stamp = now_us + $urandom_range(0, 150000);
        else stamp = $urandom();
      end else if (pick < 90) begin
        if (lo > 0 && ($urandom_range(0, 1) == 0 || hi >= 65535))
          dist_cm = 16'($urandom_range(0, lo - 1));
        else if (hi < 65535)
          dist_cm = 16'($urandom_range(hi + 1, 65535));
        now_us = now_us + dt;
        stamp  = now_us;
      end else begin
        op    = op_e'($urandom_range(0, 1));
        stamp = $urandom();
        if (op == OP_READING) now_us = stamp;
      end
      if (op == OP_READING && dist_cm >= cfg_min && dist_cm <= cfg_max) last_accept_us = stamp;
      add_sample(op, dist_cm, stamp);
    end
  endtask

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: absent data, window edges, seeding, saturation, wrap
    add_sample(OP_QUERY,   16'hFFFF, 32'd0);
    add_sample(OP_READING, 16'd0,    32'd0);
    add_sample(OP_READING, 16'hFFFF, 32'hFFFF_FFFF);
    add_sample(OP_READING, 16'd19,   32'd10);
    add_sample(OP_READING, 16'd2501, 32'd10);
    add_sample(OP_READING, 16'd20,   32'd1000);
    add_sample(OP_QUERY,   16'd0,    32'd1000);
    add_sample(OP_READING, 16'd20,   32'd1000);
    add_sample(OP_READING, 16'd2500, 32'd1001);
    add_sample(OP_READING, 16'd2400, 32'd11001);
    add_sample(OP_READING, 16'd2200, 32'd21001);
    add_sample(OP_READING, 16'd2000, 32'd31001);
    add_sample(OP_READING, 16'd1800, 32'd41001);
    add_sample(OP_READING, 16'd1600, 32'd61001);
    add_sample(OP_QUERY,   16'd0,    32'd161001);
    add_sample(OP_QUERY,   16'd0,    32'd161002);
    add_sample(OP_QUERY,   16'd0,    32'd61000);
    add_sample(OP_READING, 16'd1500, 32'hFFFF_FFF0);
    add_sample(OP_READING, 16'd1400, 32'h0000_0010);
    add_sample(OP_QUERY,   16'hFFFF, 32'hFFFF_FFFF);
    now_us         = 32'h0000_0010;
    last_accept_us = 32'h0000_0010;
    track_cm       = 1400;
    wait_idle();

    write_all(32'd1, 32'd65535, 32'd0, 32'hFFFF_FFFF);
    add_random_samples(170);
    wait_idle();
    write_all(32'd100, 32'd5000, 32'd50000, 32'd100000);
    add_random_samples(170);
    wait_idle();
    write_all(32'd65535, 32'd65535, 32'hFFFF_FFFF, 32'd0);
    add_random_samples(120);
    wait_idle();
    // inverted window, every reading misses
    write_all(32'd3000, 32'd200, 32'd1000, 32'd5000);
    add_random_samples(40);
    wait_idle();
    write_all(32'd1, 32'd1, 32'd0, 32'd0);
    add_random_samples(100);
    wait_idle();
    write_all(32'd20, 32'd2500, 32'd50000, 32'd100000);
    add_random_samples(220);
    wait_idle();
    for (int p = 0; p < 3; p++) begin
      lo = $urandom_range(1, 40000);
      hi = $urandom_range(lo, 65535);
      if (p == 2) write_all(lo, hi, $urandom(), $urandom());
      else write_all(lo, hi, $urandom_range(0, 300000), $urandom_range(0, 400000));
      add_random_samples(200);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("** range_velocity_tracker: PASSED **");
    end else begin
      $display("** range_velocity_tracker: FAILED **");
    end
    $finish;
  end

endmodule
